// File: rtl/packet_rate_bandwidth_monitor_core_defines.svh
// ----------------------------------------------------------------------------
// Packet rate and bandwidth monitor: assertion macros
// Shared macros for the concurrent checks on the monitor's ports.
// ----------------------------------------------------------------------------
`ifndef PACKET_RATE_BANDWIDTH_MONITOR_CORE_DEFINES_SVH
`define PACKET_RATE_BANDWIDTH_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define PRBM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define PRBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/prbm_pkg.sv
// ----------------------------------------------------------------------------
// Packet rate and bandwidth monitor: package
// Constants, register indexes and the control struct of the shared MAC unit.
// ----------------------------------------------------------------------------
package prbm_pkg;

    localparam int RATE_FRAC_BITS_DEF = 8;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP = 1'b1;

    localparam int ALPHA_W = 17;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd32768;
    localparam logic [31:0]        RECIP_RESET = 32'd655360;

    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // Operand width of the shared multiplier and width of its accumulator.
    localparam int MUL_W = 32;
    localparam int ACC_W = 3 * MUL_W;

    typedef struct packed {
        logic acc_en;   // add the registered product into the accumulator
        logic clr;      // start a fresh sum instead of adding to the old one
        logic hi;       // the product belongs to the upper operand half
    } mac_ctrl_t;

endpackage

// File: rtl/prbm_item_if.sv
// ----------------------------------------------------------------------------
// Packet rate and bandwidth monitor: input channel
// Valid/ready channel carrying one packet or period-tick item.
// ----------------------------------------------------------------------------
interface prbm_item_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] wire_len;
    logic [15:0] cap_len;

    modport source (output valid, output func, output wire_len, output cap_len,
                    input ready);
    modport sink (input valid, input func, input wire_len, input cap_len,
                  output ready);
endinterface

// File: rtl/prbm_result_if.sv
// ----------------------------------------------------------------------------
// Packet rate and bandwidth monitor: result channel
// Valid/ready channel carrying the averages and totals after each tick.
// ----------------------------------------------------------------------------
interface prbm_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] pkt_avg_rate;
    logic [63:0] cap_octet_total;
    logic [63:0] cap_bw;
    logic [63:0] link_octet_total;
    logic [63:0] link_bw;

    modport source (output valid, output pkt_avg_rate, output cap_octet_total,
                    output cap_bw, output link_octet_total, output link_bw,
                    input ready);
    modport sink (input valid, input pkt_avg_rate, input cap_octet_total,
                  input cap_bw, input link_octet_total, input link_bw,
                  output ready);
endinterface

// File: rtl/prbm_mac.sv
// ----------------------------------------------------------------------------
// Packet rate and bandwidth monitor: shared multiply-accumulate unit
// One 32x32 multiplier with a registered product and a 96-bit accumulator.
// ----------------------------------------------------------------------------
module prbm_mac
    import prbm_pkg::*;
(
    input  logic             clk,
    input  mac_ctrl_t        ctrl,
    input  logic [MUL_W-1:0] op_a,
    input  logic [MUL_W-1:0] op_b,
    output logic [ACC_W-1:0] acc
);

    logic [2*MUL_W-1:0] prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W-1:0]   base;

    always_comb
    begin
        if (ctrl.hi)
        begin
            addend = {prod_reg, {MUL_W{1'b0}}};
        end
        else
        begin
            addend = {{MUL_W{1'b0}}, prod_reg};
        end
        base = ctrl.clr ? '0 : acc_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (ctrl.acc_en)
        begin
            acc_reg <= base + addend;
        end
    end

    assign acc = acc_reg;

endmodule

// File: rtl/packet_rate_bandwidth_monitor_core.sv
// ----------------------------------------------------------------------------
// Packet rate and bandwidth monitor
// Counts packets and bytes and keeps moving-average rates per period tick.
// ----------------------------------------------------------------------------
// A packet item (func = 0) is absorbed in the cycle of its transfer: the
// interval packet count goes up by one (saturating at 2^32-1) and the wire
// and captured lengths are added to two wrapping 64-bit byte totals, so
// packets can stream in at one per cycle. A tick item (func = 1) closes the
// measurement period. For each of packets, captured bytes and wire bytes the
// block multiplies the interval count by the reciprocal period, scales it to
// RATE_FRAC_BITS fraction bits (bytes also times eight for bits), saturates
// it to 64 bits and folds it into an exponential moving average weighted by
// alpha on the newest sample. All of this runs on one shared 32x32
// multiplier and a 96-bit accumulator under a small sequencer: each of the
// three quantities takes six multiply-accumulate steps, a scaling state and
// an update state. A tick holds the input channel off until its result is
// published, which waits while the previous result is not yet taken. The
// result is held in an output register; packets are accepted again while
// it waits. Alpha writes above 1.0 are clamped to 1.0; a reciprocal period
// of zero gives zero samples. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module packet_rate_bandwidth_monitor_core
    import prbm_pkg::*;
#(
    parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    prbm_item_if.sink             item,
    prbm_result_if.source         result
);

    // Right shift that brings a product of count and Q16.16 reciprocal to
    // RATE_FRAC_BITS fraction bits. Bytes are also multiplied by eight, which
    // is three bits less of right shift; a negative amount is a left shift.
    localparam int PKT_SH  = 16 - RATE_FRAC_BITS;
    localparam int BYTE_SH = 13 - RATE_FRAC_BITS;
    localparam int EXT_W   = ACC_W + 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_NARROW,
        S_AVG,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        CH_PKT,
        CH_CAP,
        CH_LINK
    } chan_t;

    // Multiply steps: two for the sample, four for the moving average.
    typedef enum logic [2:0] {
        OP_CNT_LO,
        OP_CNT_HI,
        OP_SMP_LO,
        OP_SMP_HI,
        OP_AVG_LO,
        OP_AVG_HI
    } op_t;

    // Shift by a constant amount and saturate the result to 64 bits.
    function automatic logic [63:0] narrow_sat(input logic [ACC_W-1:0] x,
                                               input int sh);
        logic [EXT_W-1:0] ext;
        ext = {{(EXT_W-ACC_W){1'b0}}, x};
        if (sh >= 0)
        begin
            ext = ext >> sh;
        end
        else
        begin
            ext = ext << (-sh);
        end
        return (|ext[EXT_W-1:64]) ? {64{1'b1}} : ext[63:0];
    endfunction

    state_t             state_reg;
    chan_t              ch_reg;
    op_t                op_reg;
    op_t                op_next;

    logic [ALPHA_W-1:0] alpha_reg;
    logic [ALPHA_W-1:0] alpha_next;
    logic [ALPHA_W-1:0] ialpha;
    logic [31:0]        recip_reg;

    logic [31:0]        ipk_reg;
    logic [63:0]        cap_total_reg;
    logic [63:0]        cap_last_reg;
    logic [63:0]        link_total_reg;
    logic [63:0]        link_last_reg;
    logic [63:0]        avg_pkt_reg;
    logic [63:0]        avg_cap_reg;
    logic [63:0]        avg_link_reg;

    logic [63:0]        sample_reg;
    logic [63:0]        sample_next;
    logic [63:0]        cnt;
    logic [63:0]        prev;
    logic [63:0]        avg_new;

    logic               res_valid_reg;
    logic [63:0]        pkt_avg_rate_reg;
    logic [63:0]        cap_octet_reg;
    logic [63:0]        cap_bw_reg;
    logic [63:0]        link_octet_reg;
    logic [63:0]        link_bw_reg;

    mac_ctrl_t          mac_ctrl;
    logic [MUL_W-1:0]   mac_a;
    logic [MUL_W-1:0]   mac_b;
    logic [ACC_W-1:0]   mac_acc;

    // Writes of alpha above one are clamped to one.
    assign alpha_next = (cfg_wdata[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE
                                                             : cfg_wdata[ALPHA_W-1:0];
    assign ialpha = ALPHA_ONE - alpha_reg;

    // Interval count and previous average of the quantity in work.
    always_comb
    begin
        case (ch_reg)
            CH_PKT:
            begin
                cnt  = {32'b0, ipk_reg};
                prev = avg_pkt_reg;
            end
            CH_CAP:
            begin
                cnt  = cap_total_reg - cap_last_reg;
                prev = avg_cap_reg;
            end
            CH_LINK:
            begin
                cnt  = link_total_reg - link_last_reg;
                prev = avg_link_reg;
            end
            default:
            begin
                cnt  = '0;
                prev = '0;
            end
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (op_reg)
            OP_CNT_LO:
            begin
                mac_a = cnt[31:0];
                mac_b = recip_reg;
            end
            OP_CNT_HI:
            begin
                mac_a = cnt[63:32];
                mac_b = recip_reg;
            end
            OP_SMP_LO:
            begin
                mac_a = sample_reg[31:0];
                mac_b = {{(MUL_W-ALPHA_W){1'b0}}, alpha_reg};
            end
            OP_SMP_HI:
            begin
                mac_a = sample_reg[63:32];
                mac_b = {{(MUL_W-ALPHA_W){1'b0}}, alpha_reg};
            end
            OP_AVG_LO:
            begin
                mac_a = prev[31:0];
                mac_b = {{(MUL_W-ALPHA_W){1'b0}}, ialpha};
            end
            OP_AVG_HI:
            begin
                mac_a = prev[63:32];
                mac_b = {{(MUL_W-ALPHA_W){1'b0}}, ialpha};
            end
            default:
            begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_CNT_LO: op_next = OP_CNT_HI;
            OP_SMP_LO: op_next = OP_SMP_HI;
            OP_SMP_HI: op_next = OP_AVG_LO;
            OP_AVG_LO: op_next = OP_AVG_HI;
            default:   op_next = op_reg;
        endcase
    end

    assign mac_ctrl.acc_en = (state_reg == S_ACC);
    assign mac_ctrl.clr    = (op_reg == OP_CNT_LO) || (op_reg == OP_SMP_LO);
    assign mac_ctrl.hi     = (op_reg == OP_CNT_HI) || (op_reg == OP_SMP_HI)
                          || (op_reg == OP_AVG_HI);

    // The packet sample and the byte samples differ only in their scaling.
    assign sample_next = (ch_reg == CH_PKT) ? narrow_sat(mac_acc, PKT_SH)
                                            : narrow_sat(mac_acc, BYTE_SH);

    // The weighted sum stays below 2^80, so dropping 16 bits always fits.
    assign avg_new = mac_acc[79:16];

    prbm_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (mac_acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ch_reg           <= CH_PKT;
            op_reg           <= OP_CNT_LO;
            alpha_reg        <= ALPHA_RESET;
            recip_reg        <= RECIP_RESET;
            ipk_reg          <= '0;
            cap_total_reg    <= '0;
            cap_last_reg     <= '0;
            link_total_reg   <= '0;
            link_last_reg    <= '0;
            avg_pkt_reg      <= '0;
            avg_cap_reg      <= '0;
            avg_link_reg     <= '0;
            sample_reg       <= '0;
            res_valid_reg    <= 1'b0;
            pkt_avg_rate_reg <= '0;
            cap_octet_reg    <= '0;
            cap_bw_reg       <= '0;
            link_octet_reg   <= '0;
            link_bw_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ALPHA: alpha_reg <= alpha_next;
                    CFG_RECIP: recip_reg <= cfg_wdata[31:0];
                endcase
            end

            // In S_OUT the valid flag is handled by the publishing step below.
            if (res_valid_reg && result.ready && (state_reg != S_OUT))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        if (item.func == FUNC_TICK)
                        begin
                            ch_reg    <= CH_PKT;
                            op_reg    <= OP_CNT_LO;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            if (ipk_reg != '1)
                            begin
                                ipk_reg <= ipk_reg + 32'd1;
                            end
                            cap_total_reg  <= cap_total_reg + {48'b0, item.cap_len};
                            link_total_reg <= link_total_reg + {48'b0, item.wire_len};
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (op_reg == OP_CNT_HI)
                    begin
                        state_reg <= S_NARROW;
                    end
                    else if (op_reg == OP_AVG_HI)
                    begin
                        state_reg <= S_AVG;
                    end
                    else
                    begin
                        op_reg    <= op_next;
                        state_reg <= S_MUL;
                    end
                end
                S_NARROW:
                begin
                    sample_reg <= sample_next;
                    op_reg     <= OP_SMP_LO;
                    state_reg  <= S_MUL;
                end
                S_AVG:
                begin
                    op_reg <= OP_CNT_LO;
                    case (ch_reg)
                        CH_PKT:
                        begin
                            avg_pkt_reg <= avg_new;
                            ch_reg      <= CH_CAP;
                            state_reg   <= S_MUL;
                        end
                        CH_CAP:
                        begin
                            avg_cap_reg <= avg_new;
                            ch_reg      <= CH_LINK;
                            state_reg   <= S_MUL;
                        end
                        CH_LINK:
                        begin
                            avg_link_reg <= avg_new;
                            state_reg    <= S_OUT;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_OUT:
                begin
                    // Wait until the output register is free, then publish the
                    // result and open a new interval.
                    if (!res_valid_reg || result.ready)
                    begin
                        res_valid_reg    <= 1'b1;
                        pkt_avg_rate_reg <= avg_pkt_reg;
                        cap_octet_reg    <= cap_total_reg;
                        cap_bw_reg       <= avg_cap_reg;
                        link_octet_reg   <= link_total_reg;
                        link_bw_reg      <= avg_link_reg;
                        ipk_reg          <= '0;
                        cap_last_reg     <= cap_total_reg;
                        link_last_reg    <= link_total_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item.ready              = (state_reg == S_IDLE);
    assign result.valid            = res_valid_reg;
    assign result.pkt_avg_rate     = pkt_avg_rate_reg;
    assign result.cap_octet_total  = cap_octet_reg;
    assign result.cap_bw           = cap_bw_reg;
    assign result.link_octet_total = link_octet_reg;
    assign result.link_bw          = link_bw_reg;

endmodule

// File: rtl/prbm_checker.sv
// ----------------------------------------------------------------------------
// Packet rate and bandwidth monitor: port checker
// Concurrent checks on the monitor's channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_rate_bandwidth_monitor_core_defines.svh"

module prbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        item_func,
    input logic        result_valid,
    input logic        result_ready,
    input logic [63:0] result_cap_octet_total
);

    // A tick occupies the sequencer, so the input must close right after it.
    `PRBM_ASSERT_NEXT(a_tick_blocks, item_valid && item_ready && item_func, !item_ready, "input still open after a tick transfer")

    // A packet is absorbed in the cycle of its transfer and leaves the input open.
    `PRBM_ASSERT_NEXT(a_pkt_single_cycle, item_valid && item_ready && !item_func, item_ready, "input closed after a packet transfer")

    `PRBM_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

    `PRBM_ASSERT_NEXT(a_res_stable, result_valid && !result_ready, $stable(result_cap_octet_total), "stalled result changed")

endmodule

bind packet_rate_bandwidth_monitor_core prbm_checker u_prbm_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .item_valid             (item.valid),
    .item_ready             (item.ready),
    .item_func              (item.func),
    .result_valid           (result.valid),
    .result_ready           (result.ready),
    .result_cap_octet_total (result.cap_octet_total)
);

// File: tb/tb_packet_rate_bandwidth_monitor_core.sv
// ----------------------------------------------------------------------------
// Packet rate and bandwidth monitor: self-checking testbench
// Streams packet and period-tick transfers into the monitor under random
// valid/ready gaps, predicts every moving-average result in a scoreboard
// and compares each result transfer field by field, over several alpha and
// reciprocal-period settings including both ends of each range.
// ----------------------------------------------------------------------------
module tb_packet_rate_bandwidth_monitor_core;
    import prbm_pkg::*;

    // Rate arithmetic uses the block's default fraction width.
    localparam int RATE_FRAC = RATE_FRAC_BITS_DEF;

    // A tick keeps the sequencer busy; this settle time is longer than that and
    // is waited before touching the registers or deciding the run is over.
    localparam int SETTLE_CYCLES = 64;

    // Cycles without any transfer after which the run is declared hung. The
    // longest quiet stretch in a correct run is the receiver hold-off plus
    // one tick computation, so this leaves a wide margin.
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic        func;
        logic [15:0] wire_len;
        logic [15:0] cap_len;
    } packet_event_t;

    typedef struct packed {
        logic [63:0] pkt_avg_rate;
        logic [63:0] cap_octet_total;
        logic [63:0] cap_bw;
        logic [63:0] link_octet_total;
        logic [63:0] link_bw;
    } rate_report_t;

    // Tracks the meter's counters and averages and holds the reports that
    // the accepted ticks must produce, oldest first.
    class rate_average_tracker;
        bit [16:0] alpha;
        bit [31:0] recip_period;
        bit [31:0] interval_pkts;
        bit [63:0] cap_octets;
        bit [63:0] cap_octets_mark;
        bit [63:0] link_octets;
        bit [63:0] link_octets_mark;
        bit [63:0] avg_pkt;
        bit [63:0] avg_cap;
        bit [63:0] avg_link;
        rate_report_t expected_reports[$];
        int errors;
        int packets;
        int ticks;
        int reports_seen;

        function new();
            alpha = ALPHA_RESET;
            recip_period = RECIP_RESET;
        endfunction

        // Alpha keeps 17 bits of the written word and clamps to 1.0.
        function void set_registers(bit [31:0] alpha_word, bit [31:0] recip_word);
            bit [16:0] a;
            a = alpha_word[16:0];
            alpha = (a > ALPHA_ONE) ? ALPHA_ONE : a;
            recip_period = recip_word;
        endfunction

        // count * recip_period, shifted right (left when negative), then
        // saturated to 64 bits.
        function bit [63:0] scale_to_rate(bit [63:0] count, int shift);
            bit [127:0] prod;
            prod = {64'd0, count} * {96'd0, recip_period};
            if (shift >= 0)
                prod = prod >> shift;
            else
                prod = prod << (-shift);
            return (prod[127:64] != 0) ? {64{1'b1}} : prod[63:0];
        endfunction

        function bit [63:0] blend_average(bit [63:0] prev, bit [63:0] rate);
            bit [127:0] acc;
            bit [127:0] keep;
            keep = 128'd65536 - {111'd0, alpha};
            acc = {64'd0, rate} * {111'd0, alpha} + {64'd0, prev} * keep;
            acc = acc >> 16;
            return (acc[127:64] != 0) ? {64{1'b1}} : acc[63:0];
        endfunction

        function void note_item(packet_event_t it);
            bit [63:0] cap_delta;
            bit [63:0] link_delta;
            bit [63:0] r_pkt;
            bit [63:0] r_cap;
            bit [63:0] r_link;
            rate_report_t rep;
            if (it.func == FUNC_PACKET) begin
                if (interval_pkts != 32'hFFFF_FFFF)
                    interval_pkts++;
                cap_octets += {48'd0, it.cap_len};
                link_octets += {48'd0, it.wire_len};
                packets++;
            end
            else begin
                cap_delta = cap_octets - cap_octets_mark;
                link_delta = link_octets - link_octets_mark;
                // Packets scale to the fraction width; bytes also times 8.
                r_pkt = scale_to_rate({32'd0, interval_pkts}, 16 - RATE_FRAC);
                r_cap = scale_to_rate(cap_delta, 13 - RATE_FRAC);
                r_link = scale_to_rate(link_delta, 13 - RATE_FRAC);
                interval_pkts = 0;
                cap_octets_mark = cap_octets;
                link_octets_mark = link_octets;
                avg_pkt = blend_average(avg_pkt, r_pkt);
                avg_cap = blend_average(avg_cap, r_cap);
                avg_link = blend_average(avg_link, r_link);
                rep.pkt_avg_rate = avg_pkt;
                rep.cap_octet_total = cap_octets;
                rep.cap_bw = avg_cap;
                rep.link_octet_total = link_octets;
                rep.link_bw = avg_link;
                expected_reports.push_back(rep);
                ticks++;
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_report(rate_report_t got);
            rate_report_t want;
            reports_seen++;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: result transfer with none expected, actual pkt_avg_rate %0d",
                         $time, got.pkt_avg_rate);
            end
            else begin
                want = expected_reports.pop_front();
                compare_field("pkt_avg_rate", want.pkt_avg_rate, got.pkt_avg_rate);
                compare_field("cap_octet_total", want.cap_octet_total,
                              got.cap_octet_total);
                compare_field("cap_bw", want.cap_bw, got.cap_bw);
                compare_field("link_octet_total", want.link_octet_total,
                              got.link_octet_total);
                compare_field("link_bw", want.link_bw, got.link_bw);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    prbm_item_if   item_bus();
    prbm_result_if result_bus();

    packet_rate_bandwidth_monitor_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_bus),
        .result    (result_bus)
    );

    rate_average_tracker tracker = new();

    // Idle percentages of the two sides; the main sequence changes them per
    // phase. A nonzero hold request makes the receiver drop ready for that
    // many cycles, counted in the receiver's own loop.
    int src_idle_pct = 21;
    int snk_idle_pct = 21;
    int hold_request = 0;
    int settings_used = 1;

    function automatic bit roll_idle(int pct);
        return $urandom_range(99) < pct;
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: ready is driven at each rising edge, and a result counts as
    // transferred when valid and ready were both high at that edge.
    initial begin : result_sink
        int hold_left;
        rate_report_t got;
        hold_left = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready) begin
                got.pkt_avg_rate = result_bus.pkt_avg_rate;
                got.cap_octet_total = result_bus.cap_octet_total;
                got.cap_bw = result_bus.cap_bw;
                got.link_octet_total = result_bus.link_octet_total;
                got.link_bw = result_bus.link_bw;
                tracker.check_report(got);
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else begin
                result_bus.ready <= !roll_idle(snk_idle_pct);
            end
        end
    end

    // Watchdog: any run that goes this long without a transfer on either
    // channel is hung.
    initial begin : stall_watch
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet > STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet, tracker.expected_reports.size());
                $display("tb_packet_rate_bandwidth_monitor_core: done, errors");
                $finish;
            end
        end
    end

    // Offer one item after a random number of idle cycles and wait for its
    // transfer. Valid stays high across back-to-back items.
    task automatic send_item(packet_event_t it);
        while (roll_idle(src_idle_pct)) begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.func <= it.func;
        item_bus.wire_len <= it.wire_len;
        item_bus.cap_len <= it.cap_len;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        tracker.note_item(it);
    endtask

    task automatic send_packet(logic [15:0] wire_len, logic [15:0] cap_len);
        packet_event_t it;
        it.func = FUNC_PACKET;
        it.wire_len = wire_len;
        it.cap_len = cap_len;
        send_item(it);
    endtask

    // Tick payload lengths are ignored by the block, so they carry noise.
    task automatic send_tick();
        packet_event_t it;
        it.func = FUNC_TICK;
        it.wire_len = 16'($urandom);
        it.cap_len = 16'($urandom);
        send_item(it);
    endtask

    // The sender stops until every predicted result has been taken, then
    // lets the sequencer settle, because a packet transfer leaves no result
    // to wait for.
    task automatic drain_results();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write enable stays high over both writes; it is lowered once.
    task automatic write_registers(logic [31:0] alpha_word, logic [31:0] recip_word);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ALPHA;
        cfg_wdata <= alpha_word;
        @(posedge clk);
        cfg_index <= CFG_RECIP;
        cfg_wdata <= recip_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_registers(alpha_word, recip_word);
        settings_used++;
    endtask

    // Random traffic: mostly packets with a tick every ten or so transfers.
    // Lengths mix full-range noise, ordinary frames, snapped captures and
    // captures masked from the frame length.
    task automatic send_random_traffic(int count);
        logic [15:0] wire_len;
        logic [15:0] cap_len;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 9) begin
                send_tick();
            end
            else begin
                case ($urandom_range(3))
                    0: begin
                        wire_len = 16'($urandom);
                        cap_len = 16'($urandom);
                    end
                    1: begin
                        wire_len = 16'($urandom_range(1518, 64));
                        cap_len = wire_len;
                    end
                    2: begin
                        wire_len = 16'($urandom_range(9000, 64));
                        cap_len = (wire_len > 16'd128) ? 16'd128 : wire_len;
                    end
                    default: begin
                        wire_len = 16'($urandom);
                        cap_len = wire_len & 16'($urandom);
                    end
                endcase
                send_packet(wire_len, cap_len);
            end
        end
    endtask

    initial begin : main_sequence
        logic [31:0] alpha_word;
        logic [31:0] recip_word;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_ALPHA;
        cfg_wdata <= '0;
        item_bus.valid <= 1'b0;
        item_bus.func <= FUNC_PACKET;
        item_bus.wire_len <= '0;
        item_bus.cap_len <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings: an empty interval, the
        // length extremes and alternating bit patterns, back-to-back ticks.
        send_tick();
        send_packet(16'd0, 16'd0);
        send_packet(16'hFFFF, 16'hFFFF);
        send_packet(16'hAAAA, 16'h5555);
        send_packet(16'h5555, 16'hAAAA);
        send_packet(16'd1500, 16'd64);
        send_tick();
        send_tick();
        drain_results();

        // Alpha of exactly one with the smallest nonzero period register.
        write_registers(32'd65536, 32'd1);
        send_packet(16'hFFFF, 16'd0);
        send_packet(16'd64, 16'd64);
        send_tick();
        drain_results();

        // Alpha zero keeps the averages frozen; largest period register.
        write_registers(32'd0, 32'hFFFF_FFFF);
        send_packet(16'hFFFF, 16'hFFFF);
        send_packet(16'hFFFF, 16'hFFFF);
        send_tick();
        drain_results();

        // Alpha above one is clamped to one; a zero period register gives
        // zero samples, so the averages fall straight to zero.
        write_registers(32'h0001_FFFF, 32'd0);
        send_packet(16'd1000, 16'd200);
        send_tick();
        drain_results();

        // Upper write bits beyond the alpha field are dropped before the
        // clamp; the full period range turns long frames into large rates.
        write_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (4) send_packet(16'hFFFF, 16'hFFFF);
        send_tick();
        send_tick();
        drain_results();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    alpha_word = 32'($urandom_range(65536));
                    recip_word = $urandom;
                end
                1: begin
                    alpha_word = 32'd65536;
                    recip_word = 32'hFFFF_FFFF;
                end
                2: begin
                    alpha_word = 32'd0;
                    recip_word = 32'd1;
                end
                3: begin
                    alpha_word = 32'($urandom_range(65536));
                    recip_word = 32'($urandom_range(1 << 20));
                end
                4: begin
                    alpha_word = $urandom;
                    recip_word = 32'd0;
                end
                default: begin
                    alpha_word = 32'(ALPHA_RESET);
                    recip_word = RECIP_RESET;
                end
            endcase
            write_registers(alpha_word, recip_word);

            // One long stretch with both sides running flat out.
            src_idle_pct = (phase == 1) ? 0 : 21;
            snk_idle_pct = (phase == 1) ? 0 : 21;

            // Hold the receiver off while ticks keep coming, so that a
            // finished result sits in the output register and the next
            // tick has to stall the input channel.
            if (phase == 3) begin
                hold_request = HOLD_OFF_CYCLES;
                repeat (3) begin
                    send_tick();
                    repeat (20) send_packet(16'($urandom), 16'($urandom));
                end
            end

            send_random_traffic(245);
            drain_results();
        end

        $display("Covered %0d packet transfers and %0d ticks under %0d register settings;",
                 tracker.packets, tracker.ticks, settings_used);
        $display("checked %0d result transfers, %0d mismatches.",
                 tracker.reports_seen, tracker.errors);
        if (tracker.errors == 0 && tracker.expected_reports.size() == 0)
            $display("tb_packet_rate_bandwidth_monitor_core: done, clean");
        else
            $display("tb_packet_rate_bandwidth_monitor_core: done, errors");
        $finish;
    end

endmodule
